[hw/rtl/qof_pkg.sv]
// Shared types and constants for the quadrilateral orientation fixer.
`timescale 1ns / 1ps
`default_nettype none
package qof_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = 2 * DiffW;
  localparam int unsigned CrossW  = ProdW + 1;
  localparam int unsigned TolW    = 50;
  localparam int unsigned NumLanes = 6;

  typedef logic [1:0] slot_t;

  typedef enum logic [2:0] {
    ST_UNCHANGED  = 3'd0,
    ST_REORDERED  = 3'd1,
    ST_NONZERO_Z  = 3'd2,
    ST_DEGENERATE = 3'd3,
    ST_NOT_CONVEX = 3'd4
  } status_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  typedef struct packed {
    logic pos;
    logic neg;
    logic degen;
  } lane_flags_t;

  // corner indices per lane: origin, first, second
  localparam slot_t LANE_O [NumLanes] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1};
  localparam slot_t LANE_A [NumLanes] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0};
  localparam slot_t LANE_B [NumLanes] = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2};

endpackage
`default_nettype wire

[hw/rtl/qof_cross_lane.sv]
// One cross product lane: differences, products, difference, sign and tolerance flags.
`timescale 1ns / 1ps
`default_nettype none
module qof_cross_lane
  import qof_pkg::*;
(
  input  wire logic                      clk,
  input  wire adv_t                      adv,
  input  wire logic signed [CoordW-1:0]  ox,
  input  wire logic signed [CoordW-1:0]  oy,
  input  wire logic signed [CoordW-1:0]  ax,
  input  wire logic signed [CoordW-1:0]  ay,
  input  wire logic signed [CoordW-1:0]  bx,
  input  wire logic signed [CoordW-1:0]  by,
  input  wire logic        [TolW-1:0]    tol,
  input  wire logic signed [CrossW-1:0]  neg_tol,
  output lane_flags_t                    flags
);

  logic signed [DiffW-1:0]  dax, day, dbx, dby;
  logic signed [ProdW-1:0]  p1, p2;
  logic signed [CrossW-1:0] d;
  logic signed [CrossW-1:0] pos_tol;

  assign pos_tol = $signed({1'b0, tol});

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      dax <= $signed({ax[CoordW-1], ax}) - $signed({ox[CoordW-1], ox});
      day <= $signed({ay[CoordW-1], ay}) - $signed({oy[CoordW-1], oy});
      dbx <= $signed({bx[CoordW-1], bx}) - $signed({ox[CoordW-1], ox});
      dby <= $signed({by[CoordW-1], by}) - $signed({oy[CoordW-1], oy});
    end
    if (adv.s2) begin
      p1 <= dax * dby;
      p2 <= day * dbx;
    end
    if (adv.s3) begin
      d <= $signed({p1[ProdW-1], p1}) - $signed({p2[ProdW-1], p2});
    end
    if (adv.s4) begin
      flags.neg   <= d[CrossW-1];
      flags.pos   <= !d[CrossW-1] && (d != '0);
      flags.degen <= (d < pos_tol) && (d > neg_tol);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/qof_merge.sv]
// Merge of lane flags into the slot order and status.
`timescale 1ns / 1ps
`default_nettype none
module qof_merge
  import qof_pkg::*;
(
  input  wire lane_flags_t  lane [NumLanes],
  input  wire logic         zbad,
  output slot_t             slot0,
  output slot_t             slot1,
  output slot_t             slot2,
  output slot_t             slot3,
  output status_t           status
);

  logic [2:0] count;
  logic       degen4;
  logic       degen_sel;
  logic       d1n, d1p, d2n, d2p;

  assign count = {2'b00, lane[0].pos} + {2'b00, lane[1].pos}
               + {2'b00, lane[2].pos} + {2'b00, lane[3].pos};
  assign degen4    = lane[0].degen || lane[1].degen || lane[2].degen || lane[3].degen;
  assign degen_sel = lane[4].degen || lane[5].degen;
  assign d1n = lane[4].neg;
  assign d1p = lane[4].pos;
  assign d2n = lane[5].neg;
  assign d2p = lane[5].pos;

  always_comb begin
    slot0  = 2'd0;
    slot1  = 2'd1;
    slot2  = 2'd2;
    slot3  = 2'd3;
    status = ST_UNCHANGED;
    if (zbad) begin
      status = ST_NONZERO_Z;
    end else if (degen4) begin
      status = ST_DEGENERATE;
    end else begin
      case (count)
        3'd1, 3'd3: status = ST_NOT_CONVEX;
        3'd2: begin
          if (degen_sel) begin
            status = ST_DEGENERATE;
          end else begin
            status = ST_REORDERED;
            if (d1n && d2n) begin
              slot0 = 2'd3;
              slot3 = 2'd0;
            end else if (d1n && d2p) begin
              slot0 = 2'd1;
              slot1 = 2'd0;
            end else if (d1p && d2n) begin
              slot2 = 2'd3;
              slot3 = 2'd2;
            end else begin
              slot1 = 2'd2;
              slot2 = 2'd1;
            end
          end
        end
        3'd4: begin
          status = ST_REORDERED;
          slot0  = 2'd3;
          slot1  = 2'd2;
          slot2  = 2'd1;
          slot3  = 2'd0;
        end
        default: status = ST_UNCHANGED;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/quad_orientation_fixer.sv]
// Quadrilateral orientation fixer: checks four corners, returns a corner order and status.
//
// Input channel: item_valid / item_stall with the twelve corner coordinates
// x0..z3 (signed Q12.12). Output channel: result_valid / result_stall with
// slot0_source..slot3_source and status. A word moves at a rising edge where
// valid is high and stall is low.
// Tolerance is written with wr_en / wr_data (Q26.24 magnitude); write it only
// while no word is in flight.
// Six cross product lanes run side by side: four corner turns and the two
// swap selectors. Each lane has four stages (differences, multiply, subtract,
// flags); a merge stage forms the result into the output register.
// One word per cycle while result_stall is low; the multiply stage sets the clock.
// Reset clears all valid bits and sets the tolerance to 1.
// A stalled result holds; stages behind it keep filling until each holds a
// word, then item_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module quad_orientation_fixer
  import qof_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [TolW-1:0]          wr_data,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic signed [CoordW-1:0] x0,
  input  wire logic signed [CoordW-1:0] y0,
  input  wire logic signed [CoordW-1:0] z0,
  input  wire logic signed [CoordW-1:0] x1,
  input  wire logic signed [CoordW-1:0] y1,
  input  wire logic signed [CoordW-1:0] z1,
  input  wire logic signed [CoordW-1:0] x2,
  input  wire logic signed [CoordW-1:0] y2,
  input  wire logic signed [CoordW-1:0] z2,
  input  wire logic signed [CoordW-1:0] x3,
  input  wire logic signed [CoordW-1:0] y3,
  input  wire logic signed [CoordW-1:0] z3,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output slot_t                         slot0_source,
  output slot_t                         slot1_source,
  output slot_t                         slot2_source,
  output slot_t                         slot3_source,
  output status_t                       status
);

  logic [TolW-1:0]          tolerance;
  logic signed [CrossW-1:0] neg_tol;
  logic                     v1, v2, v3, v4;
  logic                     zb1, zb2, zb3, zb4;
  logic                     en5;
  adv_t                     adv;
  logic signed [CoordW-1:0] cx [4];
  logic signed [CoordW-1:0] cy [4];
  lane_flags_t              flags [NumLanes];
  slot_t                    m0, m1, m2, m3;
  status_t                  mstatus;

  assign cx = '{x0, x1, x2, x3};
  assign cy = '{y0, y1, y2, y3};

  assign en5        = !result_valid || !result_stall;
  assign adv.s4     = !v4 || en5;
  assign adv.s3     = !v3 || adv.s4;
  assign adv.s2     = !v2 || adv.s3;
  assign adv.s1     = !v1 || adv.s2;
  assign item_stall = !adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TolW'(1);
      neg_tol   <= -CrossW'(1);
    end else if (wr_en) begin
      tolerance <= wr_data;
      neg_tol   <= -$signed({1'b0, wr_data});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv.s1) v1 <= item_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv.s4) v4 <= v3;
      if (en5)    result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) zb1 <= (z0 != '0) || (z1 != '0) || (z2 != '0) || (z3 != '0);
    if (adv.s2) zb2 <= zb1;
    if (adv.s3) zb3 <= zb2;
    if (adv.s4) zb4 <= zb3;
    if (en5) begin
      slot0_source <= m0;
      slot1_source <= m1;
      slot2_source <= m2;
      slot3_source <= m3;
      status       <= mstatus;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    qof_cross_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .ox      (cx[LANE_O[g]]),
      .oy      (cy[LANE_O[g]]),
      .ax      (cx[LANE_A[g]]),
      .ay      (cy[LANE_A[g]]),
      .bx      (cx[LANE_B[g]]),
      .by      (cy[LANE_B[g]]),
      .tol     (tolerance),
      .neg_tol (neg_tol),
      .flags   (flags[g])
    );
  end

  qof_merge u_merge (
    .lane   (flags),
    .zbad   (zb4),
    .slot0  (m0),
    .slot1  (m1),
    .slot2  (m2),
    .slot3  (m3),
    .status (mstatus)
  );

  a_error_identity: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_UNCHANGED && status != ST_REORDERED |->
      slot0_source == 2'd0 && slot1_source == 2'd1 &&
      slot2_source == 2'd2 && slot3_source == 2'd3)
    else $error("error status with non-identity order");

  a_reorder_moves: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_REORDERED |->
      !(slot0_source == 2'd0 && slot1_source == 2'd1 &&
        slot2_source == 2'd2 && slot3_source == 2'd3))
    else $error("reordered status with identity order");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> v1 && v2 && v3 && v4 && result_valid && result_stall)
    else $error("input stalled with a free stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    v4 && en5 |=> result_valid)
    else $error("finished word lost before output");

endmodule
`default_nettype wire
